FILE: src/jet_pkg.sv
// Shared types and constants for the Julia escape-time pixel evaluator.
// Used by jet_ctrl, jet_datapath and julia_escape_time_pixel; no dependencies.
package jet_pkg;

    // Image geometry: the mapping divides by IMAGE_SIZE, which must be a power of two
    localparam int IMAGE_SIZE = 512;
    localparam int DIV_SHIFT  = $clog2(IMAGE_SIZE);

    // Field widths
    localparam int PIX_W    = 9;
    localparam int ITER_W   = 10;
    localparam int COORD_W  = 32;
    localparam int COLOUR_W = 32;
    localparam int FRAC_W   = 28;
    localparam int SPAN_W   = COORD_W + 1;
    localparam int MPROD_W  = SPAN_W + PIX_W + 1;
    localparam int PROD_W   = 2 * COORD_W;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;
    localparam int COLOUR_PW = 23;

    // |z|^2 escape bound, 4.0 in Q8.56
    localparam logic [PROD_W:0] ESCAPE_LIMIT = (PROD_W + 1)'(1) << (2 * FRAC_W + 2);

    // colour = 0xFF * (count * 20 + 1) = count * 5100 + 255
    localparam logic [COLOUR_PW-1:0] COLOUR_STEP = COLOUR_PW'(5100);
    localparam logic [COLOUR_PW-1:0] COLOUR_BASE = COLOUR_PW'(255);

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_RE_MIN    = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_RE_MAX    = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_IM_MIN    = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_IM_MAX    = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_POINTER_X = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_POINTER_Y = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_MAX_ITER  = 3'd6;

    typedef struct packed {
        logic signed [COORD_W-1:0] re_min;
        logic signed [COORD_W-1:0] re_max;
        logic signed [COORD_W-1:0] im_min;
        logic signed [COORD_W-1:0] im_max;
        logic [PIX_W-1:0]          pointer_x;
        logic [PIX_W-1:0]          pointer_y;
        logic [ITER_W-1:0]         max_iter;
    } jet_cfg_t;

    // Datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_MAP_MUL,
        OP_MAP_ADD,
        OP_ITER_MUL,
        OP_ITER_STEP,
        OP_EMIT
    } jet_op_t;

    // Which coordinate the mapping unit is producing
    typedef enum logic [1:0] {
        MAP_ZR,
        MAP_ZI,
        MAP_CR,
        MAP_CI
    } map_sel_t;

    typedef struct packed {
        jet_op_t  op;
        map_sel_t sel;
    } jet_cmd_t;

    typedef struct packed {
        logic stop;   // escaped or iteration limit reached
    } jet_stat_t;

endpackage

FILE: src/jet_datapath.sv
// Datapath of the Julia escape-time evaluator: window mapping, z^2 + c iteration, colour.
// Depends on jet_pkg; driven by commands from jet_ctrl.
module jet_datapath
    import jet_pkg::*;
(
    input  logic                  aclk,
    input  jet_cfg_t              cfg,
    input  jet_cmd_t              cmd,
    input  logic [PIX_W-1:0]      pixel_x,
    input  logic [PIX_W-1:0]      pixel_y,
    output jet_stat_t             stat,
    output logic [ITER_W-1:0]     iterations,
    output logic [COLOUR_W-1:0]   colour
);

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi_lim;
        logic signed [PROD_W-1:0] lo_lim;
        hi_lim = 64'sh0000_0000_7FFF_FFFF;
        lo_lim = 64'shFFFF_FFFF_8000_0000;
        if (v > hi_lim) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo_lim) begin
            return 32'sh8000_0000;
        end else begin
            return v[COORD_W-1:0];
        end
    endfunction

    logic [PIX_W-1:0]           px_reg, py_reg;
    logic signed [COORD_W-1:0]  zr_reg, zi_reg, cr_reg, ci_reg;
    logic signed [MPROD_W-1:0]  mprod_reg;
    logic signed [PROD_W-1:0]   r2_reg, i2_reg, x_reg;
    logic [ITER_W-1:0]          count_reg;

    logic signed [COORD_W-1:0]  map_lo, map_hi;
    logic [PIX_W-1:0]           map_p;
    logic signed [SPAN_W-1:0]   span;
    logic signed [PIX_W:0]      p_s;
    logic signed [MPROD_W-1:0]  mprod;
    logic signed [MPROD_W-1:0]  biased;
    logic signed [MPROD_W-1:0]  offset;
    logic signed [COORD_W-1:0]  map_val;

    logic [PROD_W:0]            sq_sum;
    logic signed [PROD_W-1:0]   diff;
    logic signed [COORD_W-1:0]  zr_next, zi_next;
    logic [COLOUR_PW-1:0]       colour_prod;

    // Window mapping: lo + trunc(p * (hi - lo) / IMAGE_SIZE), saturated
    always_comb begin
        case (cmd.sel)
            MAP_ZR: begin
                map_lo = cfg.re_min; map_hi = cfg.re_max; map_p = px_reg;
            end
            MAP_ZI: begin
                map_lo = cfg.im_min; map_hi = cfg.im_max; map_p = py_reg;
            end
            MAP_CR: begin
                map_lo = cfg.re_min; map_hi = cfg.re_max; map_p = cfg.pointer_x;
            end
            MAP_CI: begin
                map_lo = cfg.im_min; map_hi = cfg.im_max; map_p = cfg.pointer_y;
            end
            default: begin
                map_lo = cfg.re_min; map_hi = cfg.re_max; map_p = px_reg;
            end
        endcase
        span  = SPAN_W'(map_hi) - SPAN_W'(map_lo);
        p_s   = {1'b0, map_p};
        mprod = span * p_s;
        // bias negatives so the shift truncates toward zero
        biased = mprod_reg + (mprod_reg[MPROD_W-1] ? MPROD_W'(IMAGE_SIZE - 1)
                                                   : MPROD_W'(0));
        offset  = biased >>> DIV_SHIFT;
        map_val = sat32(PROD_W'(map_lo) + PROD_W'(offset));
    end

    // Escape test and next z
    always_comb begin
        sq_sum    = {1'b0, r2_reg} + {1'b0, i2_reg};
        stat.stop = (sq_sum >= ESCAPE_LIMIT) || (count_reg >= cfg.max_iter);
        diff      = r2_reg - i2_reg;
        zr_next   = sat32((diff >>> FRAC_W) + PROD_W'(cr_reg));
        zi_next   = sat32((x_reg >>> (FRAC_W - 1)) + PROD_W'(ci_reg));
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                px_reg    <= pixel_x;
                py_reg    <= pixel_y;
                count_reg <= ITER_W'(1);
            end
            OP_MAP_MUL: begin
                mprod_reg <= mprod;
            end
            OP_MAP_ADD: begin
                case (cmd.sel)
                    MAP_ZR:  zr_reg <= map_val;
                    MAP_ZI:  zi_reg <= map_val;
                    MAP_CR:  cr_reg <= map_val;
                    MAP_CI:  ci_reg <= map_val;
                    default: zr_reg <= map_val;
                endcase
            end
            OP_ITER_MUL: begin
                r2_reg <= zr_reg * zr_reg;
                i2_reg <= zi_reg * zi_reg;
                x_reg  <= zr_reg * zi_reg;
            end
            OP_ITER_STEP: begin
                if (!stat.stop) begin
                    zr_reg    <= zr_next;
                    zi_reg    <= zi_next;
                    count_reg <= count_reg + ITER_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        colour_prod = COLOUR_PW'(count_reg) * COLOUR_STEP + COLOUR_BASE;
        iterations  = count_reg;
        colour      = (count_reg == cfg.max_iter) ? COLOUR_W'(0) : COLOUR_W'(colour_prod);
    end

endmodule

FILE: src/jet_ctrl.sv
// Controller of the Julia escape-time evaluator: sequences mapping, iteration and hand-off.
// Depends on jet_pkg; commands jet_datapath.
module jet_ctrl
    import jet_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    input  logic      out_free,
    input  jet_stat_t stat,
    output logic      in_ready,
    output jet_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP_MUL,
        ST_MAP_ADD,
        ST_ITER_MUL,
        ST_ITER_STEP,
        ST_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] sel_reg, sel_next;

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd.op     = OP_NONE;
        cmd.sel    = map_sel_t'(sel_reg);
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.op     = OP_LOAD;
                    sel_next   = 2'd0;
                    state_next = ST_MAP_MUL;
                end
            end
            ST_MAP_MUL: begin
                cmd.op     = OP_MAP_MUL;
                state_next = ST_MAP_ADD;
            end
            ST_MAP_ADD: begin
                cmd.op = OP_MAP_ADD;
                if (map_sel_t'(sel_reg) == MAP_CI) begin
                    state_next = ST_ITER_MUL;
                end else begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = ST_MAP_MUL;
                end
            end
            ST_ITER_MUL: begin
                cmd.op     = OP_ITER_MUL;
                state_next = ST_ITER_STEP;
            end
            ST_ITER_STEP: begin
                cmd.op     = OP_ITER_STEP;
                state_next = stat.stop ? ST_EMIT : ST_ITER_MUL;
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.op     = OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sel_reg   <= 2'd0;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

FILE: src/julia_escape_time_pixel.sv
// Top level of the Julia escape-time pixel evaluator: configuration registers,
// result register, controller and datapath. Depends on jet_pkg, jet_ctrl, jet_datapath.
//
// Usage:
//   Input stream (s_*): one transfer per pixel, s_tdata = {pad, pixel_y, pixel_x}.
//   Result stream (m_*): one transfer per pixel, m_tdata = {pad, colour, iterations}.
//   Configuration: write re_min/re_max/im_min/im_max (Q4.28), pointer_x/y and
//   max_iter through cfg_we/cfg_addr/cfg_wdata while the block is idle.
// Sequence:
//   One pixel is worked on at a time. After the input transfer the mapping unit
//   produces z and c (one shared multiplier, a multiply step and an add step per
//   value), then each iteration has a multiply step (three multipliers) and a
//   step for add/saturate and the escape test. The result is then registered
//   once the result register is free, and a new pixel is taken the cycle after;
//   the result register may still wait on m_tready while the next pixel is
//   being worked on.
// Reset (aresetn low, synchronous): restore the default window (-2..+2 on both
//   axes), pointer at 0, max_iter 100; drop any pixel in flight and empty the
//   result register. If m_tready stays low the finished pixel holds in the
//   controller until the result register frees.
module julia_escape_time_pixel
    import jet_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,    // [8:0] pixel_x, [17:9] pixel_y, [23:18] zero
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata,    // [9:0] iterations, [41:10] colour, [47:42] zero
    // configuration write port
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata
);

    jet_cfg_t           cfg_reg, cfg_next;
    jet_cmd_t           cmd;
    jet_stat_t          stat;
    logic               out_free;
    logic               out_valid_reg;
    logic [ITER_W-1:0]  out_iter_reg;
    logic [COLOUR_W-1:0] out_colour_reg;
    logic [ITER_W-1:0]  res_iter;
    logic [COLOUR_W-1:0] res_colour;

    // Configuration registers; writes to unused indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                CFG_RE_MIN:    cfg_next.re_min    = cfg_wdata;
                CFG_RE_MAX:    cfg_next.re_max    = cfg_wdata;
                CFG_IM_MIN:    cfg_next.im_min    = cfg_wdata;
                CFG_IM_MAX:    cfg_next.im_max    = cfg_wdata;
                CFG_POINTER_X: cfg_next.pointer_x = cfg_wdata[PIX_W-1:0];
                CFG_POINTER_Y: cfg_next.pointer_y = cfg_wdata[PIX_W-1:0];
                CFG_MAX_ITER:  cfg_next.max_iter  = cfg_wdata[ITER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.re_min    <= -32'sd536870912;
            cfg_reg.re_max    <= 32'sd536870912;
            cfg_reg.im_min    <= -32'sd536870912;
            cfg_reg.im_max    <= 32'sd536870912;
            cfg_reg.pointer_x <= '0;
            cfg_reg.pointer_y <= '0;
            cfg_reg.max_iter  <= ITER_W'(100);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Result register: free when empty or being drained this cycle
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.op == OP_EMIT) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload: load on hand-off, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_EMIT) begin
            out_iter_reg   <= res_iter;
            out_colour_reg <= res_colour;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_colour_reg, out_iter_reg};

    jet_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .stat     (stat),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    jet_datapath u_datapath (
        .aclk       (aclk),
        .cfg        (cfg_reg),
        .cmd        (cmd),
        .pixel_x    (s_tdata[PIX_W-1:0]),
        .pixel_y    (s_tdata[2*PIX_W-1:PIX_W]),
        .stat       (stat),
        .iterations (res_iter),
        .colour     (res_colour)
    );

`ifndef NO_ASSERTIONS
    // one pixel at a time: no second transfer straight after an accepted one
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a pixel is in flight");

    // never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> (cmd.op != OP_EMIT))
        else $error("result register overwritten while stalled");

    // the count starts at one and never wraps
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_EMIT) |=> (m_tdata[ITER_W-1:0] != '0))
        else $error("iteration count of zero emitted");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for julia_escape_time_pixel: drives pixel transfers and
// register writes, predicts escape count and colour per pixel, checks every result.
// Depends on jet_pkg and the RTL under src/.
module testbench
    import jet_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef longint unsigned u64_t;

    // Q4.28 landmarks used by the directed windows
    localparam logic signed [COORD_W-1:0] Q_TWO = 32'sd536870912;
    localparam logic signed [COORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] Q_MIN = 32'sh8000_0000;
    // Register index that maps to nothing; writes to it must be ignored
    localparam logic [CFG_AW-1:0] CFG_NO_REGISTER = 3'd7;
    // 4.0 in Q8.56, the escape bound on |z|^2
    localparam u64_t ESCAPE_Q856 = 64'd1 << (2 * FRAC_W + 2);

    // Escape-time predictor and store of expected pixel results
    class julia_pixel_checker;
        typedef struct {
            logic [ITER_W-1:0]   iterations;
            logic [COLOUR_W-1:0] colour;
        } pixel_result_t;

        jet_cfg_t      regs;
        pixel_result_t pending_pixels[$];
        int unsigned   failures;

        function new();
            regs.re_min    = -Q_TWO;
            regs.re_max    = Q_TWO;
            regs.im_min    = -Q_TWO;
            regs.im_max    = Q_TWO;
            regs.pointer_x = '0;
            regs.pointer_y = '0;
            regs.max_iter  = ITER_W'(100);
            failures       = 0;
        endfunction

        function void set_register(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] value);
            case (idx)
                CFG_RE_MIN:    regs.re_min    = value;
                CFG_RE_MAX:    regs.re_max    = value;
                CFG_IM_MIN:    regs.im_min    = value;
                CFG_IM_MAX:    regs.im_max    = value;
                CFG_POINTER_X: regs.pointer_x = value[PIX_W-1:0];
                CFG_POINTER_Y: regs.pointer_y = value[PIX_W-1:0];
                CFG_MAX_ITER:  regs.max_iter  = value[ITER_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clamp_q428(longint v);
            if (v > longint'(Q_MAX)) return longint'(Q_MAX);
            if (v < longint'(Q_MIN)) return longint'(Q_MIN);
            return v;
        endfunction

        // lo + trunc(p * (hi - lo) / IMAGE_SIZE), saturated
        function longint window_point(logic signed [COORD_W-1:0] lo,
                                      logic signed [COORD_W-1:0] hi,
                                      logic [PIX_W-1:0] p);
            longint span;
            longint offset;
            span   = longint'(hi) - longint'(lo);
            offset = (longint'(p) * span) / longint'(IMAGE_SIZE);
            return clamp_q428(longint'(lo) + offset);
        endfunction

        function int unsigned pending_count();
            return pending_pixels.size();
        endfunction

        function void note_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
            longint        zr, zi, cr, ci, re_sq, im_sq, next_re, next_im;
            int unsigned   count;
            int unsigned   limit;
            pixel_result_t want;
            zr    = window_point(regs.re_min, regs.re_max, px);
            zi    = window_point(regs.im_min, regs.im_max, py);
            cr    = window_point(regs.re_min, regs.re_max, regs.pointer_x);
            ci    = window_point(regs.im_min, regs.im_max, regs.pointer_y);
            limit = regs.max_iter;
            count = 1;
            re_sq = zr * zr;
            im_sq = zi * zi;
            // the sum of squares can reach 2^63, so compare it unsigned
            while (count < limit && (u64_t'(re_sq) + u64_t'(im_sq)) < ESCAPE_Q856) begin
                next_re = ((re_sq - im_sq) >>> FRAC_W) + cr;
                next_im = ((zr * zi) >>> (FRAC_W - 1)) + ci;
                zr      = clamp_q428(next_re);
                zi      = clamp_q428(next_im);
                re_sq   = zr * zr;
                im_sq   = zi * zi;
                count++;
            end
            want.iterations = ITER_W'(count);
            // reaching the limit marks the pixel inside the set, even on an escape
            want.colour = (count == limit) ? '0 : COLOUR_W'(32'd255 * (count * 32'd20 + 32'd1));
            pending_pixels.push_back(want);
        endfunction

        function void check_result(logic [47:0] word);
            pixel_result_t want;
            if (pending_pixels.size() == 0) begin
                failures++;
                $display("%0t: result with nothing expected, actual iterations %0d colour %h",
                         $time, word[ITER_W-1:0], word[ITER_W +: COLOUR_W]);
                return;
            end
            want = pending_pixels.pop_front();
            if (word[ITER_W-1:0] !== want.iterations) begin
                failures++;
                $display("%0t: iterations expected %0d actual %0d",
                         $time, want.iterations, word[ITER_W-1:0]);
            end
            if (word[ITER_W +: COLOUR_W] !== want.colour) begin
                failures++;
                $display("%0t: colour expected %h actual %h",
                         $time, want.colour, word[ITER_W +: COLOUR_W]);
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [23:0]       s_tdata   = '0;   // [8:0] pixel_x, [17:9] pixel_y, [23:18] zero
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [47:0]       m_tdata;          // [9:0] iterations, [41:10] colour, [47:42] zero
    logic              cfg_we    = 1'b0;
    logic [CFG_AW-1:0] cfg_addr  = '0;
    logic [CFG_DW-1:0] cfg_wdata = '0;

    julia_pixel_checker board;
    int send_idle_pct   = 0;   // chance in a hundred that the sender idles a cycle
    int ready_stall_pct = 0;   // chance in a hundred that m_tready drops a cycle
    int stall_hold      = 0;

    julia_escape_time_pixel DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Result side: check each transfer, then pick the next m_tready.
    // Now and then hold m_tready low for a long stretch, so that the next pixel
    // finishes while its predecessor still waits in the result register.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata);
        if (stall_hold > 0) begin
            stall_hold--;
            m_tready <= 1'b0;
        end else if (ready_stall_pct != 0 && $urandom_range(0, 399) == 0) begin
            stall_hold = $urandom_range(20, 300);
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= ready_stall_pct);
        end
    end

    // Select how both sides idle: none, sender, receiver, or both lightly
    task automatic set_pace(input int mode);
        case (mode)
            1:       begin send_idle_pct = 79; ready_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  ready_stall_pct = 79; end
            3:       begin send_idle_pct = 18; ready_stall_pct = 18; end
            default: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
        endcase
    endtask

    // One pixel transfer; returns at the edge where it was taken
    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
        int gap;
        gap = 0;
        if (send_idle_pct != 0) begin
            while ($urandom_range(0, 99) < send_idle_pct && gap < 60)
                gap++;
            if ($urandom_range(0, 39) == 0)
                gap = $urandom_range(50, 200);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, py, px};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_pixel(px, py);
    endtask

    // Drop valid and wait until every pixel sent so far has come back
    task automatic drain_pixels();
        s_tvalid <= 1'b0;
        while (board.pending_count() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        board.set_register(idx, value);
    endtask

    // Write the whole register set; only call while the block is idle
    task automatic configure(input logic signed [COORD_W-1:0] re_lo,
                             input logic signed [COORD_W-1:0] re_hi,
                             input logic signed [COORD_W-1:0] im_lo,
                             input logic signed [COORD_W-1:0] im_hi,
                             input logic [PIX_W-1:0] ptr_x,
                             input logic [PIX_W-1:0] ptr_y,
                             input logic [ITER_W-1:0] limit);
        write_reg(CFG_RE_MIN, re_lo);
        write_reg(CFG_RE_MAX, re_hi);
        write_reg(CFG_IM_MIN, im_lo);
        write_reg(CFG_IM_MAX, im_hi);
        write_reg(CFG_POINTER_X, CFG_DW'(ptr_x));
        write_reg(CFG_POINTER_Y, CFG_DW'(ptr_y));
        write_reg(CFG_MAX_ITER, CFG_DW'(limit));
        cfg_we <= 1'b0;
    endtask

    // Random register set: mostly a window inside +-4 around the interesting
    // region, sometimes inverted, sometimes any 32-bit bounds at all
    task automatic configure_random(input int limit_kind);
        logic signed [COORD_W-1:0] re_lo, re_hi, im_lo, im_hi, centre, half;
        logic [ITER_W-1:0]         limit;
        int                        shape;
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
            re_lo = $urandom;
            re_hi = $urandom;
            im_lo = $urandom;
            im_hi = $urandom;
        end else begin
            centre = $urandom_range(0, 1 << 30) - (1 << 29);
            half   = $urandom_range(1 << 18, 1 << 29);
            re_lo  = centre - half;
            re_hi  = centre + half;
            centre = $urandom_range(0, 1 << 30) - (1 << 29);
            half   = $urandom_range(1 << 18, 1 << 29);
            im_lo  = centre - half;
            im_hi  = centre + half;
            if (shape == 1) begin
                centre = re_lo; re_lo = re_hi; re_hi = centre;
                centre = im_lo; im_lo = im_hi; im_hi = centre;
            end
        end
        case (limit_kind)
            2:       limit = ITER_W'($urandom_range(500, 1023));
            1:       limit = ITER_W'($urandom_range(61, 200));
            default: limit = ITER_W'($urandom_range(1, 60));
        endcase
        configure(re_lo, re_hi, im_lo, im_hi, PIX_W'($urandom_range(0, 511)),
                  PIX_W'($urandom_range(0, 511)), limit);
    endtask

    initial begin
        int items;
        int limit_kind;
        board = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset window and limit, corners and alternating bit patterns
        set_pace(0);
        send_pixel(9'd0,   9'd0);
        send_pixel(9'd511, 9'd511);
        send_pixel(9'd0,   9'd511);
        send_pixel(9'd511, 9'd0);
        send_pixel(9'd256, 9'd256);
        send_pixel(9'h155, 9'h0AA);
        send_pixel(9'h0AA, 9'h155);
        send_pixel(9'd1,   9'd1);
        drain_pixels();

        // c = 0 with z = 0 never escapes: run to the deepest limit
        configure(-Q_TWO, Q_TWO, -Q_TWO, Q_TWO, 9'd256, 9'd256, 10'd1023);
        send_pixel(9'd256, 9'd256);
        send_pixel(9'd300, 9'd220);
        drain_pixels();

        // Zero limit: no iteration, count 1, coloured as an escape
        configure(-Q_TWO, Q_TWO, -Q_TWO, Q_TWO, 9'd256, 9'd256, 10'd0);
        send_pixel(9'd256, 9'd256);
        send_pixel(9'd0,   9'd511);
        drain_pixels();

        // Limits of one and two: escapes on the last step still give colour 0
        configure(-Q_TWO, Q_TWO, -Q_TWO, Q_TWO, 9'd400, 9'd100, 10'd1);
        send_pixel(9'd256, 9'd256);
        send_pixel(9'd511, 9'd0);
        drain_pixels();
        configure(-Q_TWO, Q_TWO, -Q_TWO, Q_TWO, 9'd400, 9'd100, 10'd2);
        send_pixel(9'd64,  9'd64);
        send_pixel(9'd448, 9'd300);
        send_pixel(9'd200, 9'd360);
        drain_pixels();

        // Full 32-bit window: saturation of z and c
        configure(Q_MIN, Q_MAX, Q_MIN, Q_MAX, 9'd511, 9'd0, 10'd1023);
        send_pixel(9'd256, 9'd256);
        send_pixel(9'd0,   9'd0);
        send_pixel(9'd511, 9'd511);
        drain_pixels();

        // Write to an unused index, then an inverted window
        write_reg(CFG_NO_REGISTER, 32'hFFFF_FFFF);
        cfg_we <= 1'b0;
        send_pixel(9'd257, 9'd255);
        drain_pixels();
        configure(Q_TWO, -Q_TWO, Q_TWO, -Q_TWO, 9'd300, 9'd180, 10'd50);
        send_pixel(9'd0,   9'd0);
        send_pixel(9'd511, 9'd128);
        send_pixel(9'd200, 9'd330);
        drain_pixels();

        // Random phases, cycling through the idling patterns; deep limits are
        // kept to short phases so the run stays bounded
        for (int phase = 0; phase < 16; phase++) begin
            set_pace(phase % 4);
            limit_kind = (phase == 9) ? 2 : ($urandom_range(0, 4) == 0 ? 1 : 0);
            configure_random(limit_kind);
            items = (limit_kind == 2) ? 8 : 40;
            repeat (items)
                send_pixel(PIX_W'($urandom_range(0, 511)), PIX_W'($urandom_range(0, 511)));
            drain_pixels();
        end

        repeat (20) @(posedge aclk);
        if (board.failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
